// ===== rtl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, constants and the phase sequence tables of the I2C bit-level
// master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int TICK_COUNTER_WIDTH_DEF = 16;
    localparam int PHASE_TICKS_WIDTH      = 16;
    localparam logic [PHASE_TICKS_WIDTH-1:0] PHASE_TICKS_RESET = 16'd10;
    localparam int APB_ADDR_WIDTH         = 3;
    localparam int APB_DATA_WIDTH         = 32;
    localparam int PHASE_INDEX_WIDTH      = 6;

    typedef enum logic [0:0] {
        REG_PHASE_TICKS = 1'b0
    } reg_index_t;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_ADDR  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_IDLE  = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ACT_NOP    = 4'd0,
        ACT_DRV    = 4'd1,
        ACT_REL    = 4'd2,
        ACT_S0     = 4'd3,
        ACT_S1     = 4'd4,
        ACT_D0     = 4'd5,
        ACT_D1     = 4'd6,
        ACT_BIT    = 4'd7,
        ACT_SACK   = 4'd8,
        ACT_SRD    = 4'd9,
        ACT_SRDDRV = 4'd10,
        ACT_ACKOUT = 4'd11
    } action_t;

    typedef struct packed {
        logic    fin;
        action_t act;
    } seq_entry_t;

    function automatic seq_entry_t mk(input logic fin, input action_t act);
        seq_entry_t e;
        e.fin = fin;
        e.act = act;
        return e;
    endfunction

    // phase list of each command, entry per phase index
    function automatic seq_entry_t seq_entry(input cmd_t cmd,
                                             input logic [PHASE_INDEX_WIDTH-1:0] idx);
        seq_entry_t e;
        e = mk(1'b0, ACT_NOP);
        case (cmd)
            CMD_START:
            begin
                case (idx)
                    6'd0: e = mk(1'b0, ACT_DRV);
                    6'd1: e = mk(1'b0, ACT_S0);
                    6'd2: e = mk(1'b0, ACT_D1);
                    6'd3: e = mk(1'b0, ACT_S1);
                    6'd4: e = mk(1'b0, ACT_D0);
                    6'd5: e = mk(1'b1, ACT_S0);
                    default: e = mk(1'b0, ACT_NOP);
                endcase
            end
            CMD_STOP:
            begin
                case (idx)
                    6'd0: e = mk(1'b0, ACT_DRV);
                    6'd1: e = mk(1'b0, ACT_S0);
                    6'd2: e = mk(1'b0, ACT_D0);
                    6'd3: e = mk(1'b0, ACT_S1);
                    6'd4: e = mk(1'b0, ACT_D1);
                    6'd5: e = mk(1'b1, ACT_NOP);
                    default: e = mk(1'b0, ACT_NOP);
                endcase
            end
            CMD_ADDR:
            begin
                case (idx) inside
                    6'd0: e = mk(1'b0, ACT_DRV);
                    6'd1, 6'd2, 6'd5, 6'd6, 6'd9, 6'd10, 6'd13, 6'd14, 6'd17, 6'd18,
                    6'd21, 6'd22, 6'd25, 6'd26, 6'd29, 6'd30, 6'd33:
                        e = mk(1'b0, ACT_S0);
                    6'd3, 6'd7, 6'd11, 6'd15, 6'd19, 6'd23, 6'd27, 6'd31:
                        e = mk(1'b0, ACT_BIT);
                    6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32:
                        e = mk(1'b0, ACT_S1);
                    6'd34: e = mk(1'b0, ACT_REL);
                    6'd35: e = mk(1'b0, ACT_S0);
                    6'd36: e = mk(1'b0, ACT_D1);
                    6'd37: e = mk(1'b0, ACT_S1);
                    6'd38: e = mk(1'b0, ACT_SACK);
                    6'd39: e = mk(1'b1, ACT_S0);
                    default: e = mk(1'b0, ACT_NOP);
                endcase
            end
            CMD_WRITE:
            begin
                case (idx) inside
                    6'd0: e = mk(1'b0, ACT_DRV);
                    6'd1, 6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23, 6'd26:
                        e = mk(1'b0, ACT_S0);
                    6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24:
                        e = mk(1'b0, ACT_BIT);
                    6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22, 6'd25:
                        e = mk(1'b0, ACT_S1);
                    6'd27: e = mk(1'b0, ACT_REL);
                    6'd28: e = mk(1'b0, ACT_S0);
                    6'd29: e = mk(1'b0, ACT_D1);
                    6'd30: e = mk(1'b0, ACT_S1);
                    6'd31: e = mk(1'b0, ACT_SACK);
                    6'd32: e = mk(1'b1, ACT_S0);
                    default: e = mk(1'b0, ACT_NOP);
                endcase
            end
            CMD_READ:
            begin
                case (idx) inside
                    6'd0: e = mk(1'b0, ACT_REL);
                    6'd1, 6'd3, 6'd20: e = mk(1'b0, ACT_S0);
                    6'd2: e = mk(1'b0, ACT_D1);
                    6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd22:
                        e = mk(1'b0, ACT_S1);
                    6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17:
                        e = mk(1'b0, ACT_SRD);
                    6'd19: e = mk(1'b0, ACT_SRDDRV);
                    6'd21: e = mk(1'b0, ACT_ACKOUT);
                    6'd23: e = mk(1'b1, ACT_S0);
                    default: e = mk(1'b0, ACT_NOP);
                endcase
            end
            default: e = mk(1'b0, ACT_NOP);
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/i2c_bit_level_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// I2C master that runs start, stop, address, write byte and read byte
// sequences on SCL and SDA, one tick per request.
// ----------------------------------------------------------------------------
// Each request is one time tick and yields one result; a request is taken
// every clock cycle unless the result register is stalled, and its result
// appears in the output register on the next cycle. The state update and the
// phase table lookup sit in a single register-to-register pass. Each pin phase
// is held for phase_ticks ticks (zero counts as one, values above the tick
// counter range saturate). Commands offered while a sequence runs are dropped.
module i2c_bit_level_master_unit #(
    parameter int TICK_COUNTER_WIDTH = i2cbm_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2cbm_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [i2cbm_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [i2cbm_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                 pready,
    // request channel
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 command_valid,
    input  logic [2:0]                           opcode,
    input  logic [6:0]                           device_address,
    input  logic                                 read_not_write,
    input  logic [7:0]                           data_byte,
    input  logic                                 send_nack,
    input  logic                                 sda_sample,
    // result channel
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic                                 scl_level,
    output logic                                 sda_drive_enable,
    output logic                                 sda_level,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic [7:0]                           read_result,
    output logic                                 ack_seen
);

    localparam int TW = TICK_COUNTER_WIDTH;
    localparam int PW = i2cbm_pkg::PHASE_TICKS_WIDTH;
    localparam int LW = (TW > PW) ? TW : PW;
    localparam int XW = i2cbm_pkg::PHASE_INDEX_WIDTH;
    localparam logic [LW-1:0] TICK_MAX = LW'((33'd1 << TW) - 33'd1);

    // configuration
    logic [PW-1:0] phase_ticks_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cbm_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                i2cbm_pkg::REG_PHASE_TICKS: phase_ticks_reg <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            i2cbm_pkg::REG_PHASE_TICKS:
                prdata = {{(i2cbm_pkg::APB_DATA_WIDTH-PW){1'b0}}, phase_ticks_reg};
            default: prdata = '0;
        endcase
    end

    // phase hold limit
    logic [LW-1:0] pt_wide;
    logic [TW-1:0] tick_limit;

    always_comb
    begin
        pt_wide = LW'(phase_ticks_reg);
        if (pt_wide == '0)
            tick_limit = TW'(1);
        else if (pt_wide > TICK_MAX)
            tick_limit = TW'(TICK_MAX);
        else
            tick_limit = TW'(pt_wide);
    end

    // sequencer state
    i2cbm_pkg::cmd_t active_command_reg, active_command_next;
    logic [XW-1:0]   phase_index_reg, phase_index_next;
    logic [TW-1:0]   tick_count_reg, tick_count_next;
    logic [7:0]      shift_byte_reg, shift_byte_next;
    logic [3:0]      bit_count_reg, bit_count_next;
    logic            nack_request_reg, nack_request_next;
    logic            scl_reg, scl_next;
    logic            drive_reg, drive_next;
    logic            sda_reg, sda_next;
    logic            ack_reg, ack_next;
    logic [7:0]      read_hold_reg, read_hold_next;
    logic            done_next;

    logic            res_valid_reg;
    logic            accept;

    i2cbm_pkg::seq_entry_t entry;
    i2cbm_pkg::seq_entry_t start_entry;
    i2cbm_pkg::action_t    act;
    logic [XW-1:0]         idx_adv;
    logic                  fin;

    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;
    assign idx_adv   = phase_index_reg + XW'(1);

    always_comb
    begin
        active_command_next = active_command_reg;
        phase_index_next    = phase_index_reg;
        tick_count_next     = tick_count_reg;
        shift_byte_next     = shift_byte_reg;
        bit_count_next      = bit_count_reg;
        nack_request_next   = nack_request_reg;
        scl_next            = scl_reg;
        drive_next          = drive_reg;
        sda_next            = sda_reg;
        ack_next            = ack_reg;
        read_hold_next      = read_hold_reg;
        done_next           = 1'b0;
        act                 = i2cbm_pkg::ACT_NOP;
        fin                 = 1'b0;
        entry               = i2cbm_pkg::seq_entry(active_command_reg, idx_adv);
        start_entry         = i2cbm_pkg::seq_entry(i2cbm_pkg::cmd_t'(opcode), '0);

        if (active_command_reg == i2cbm_pkg::CMD_IDLE)
        begin
            if (command_valid && opcode <= 3'd4)
            begin
                active_command_next = i2cbm_pkg::cmd_t'(opcode);
                phase_index_next    = '0;
                bit_count_next      = '0;
                if (opcode == i2cbm_pkg::CMD_ADDR)
                    shift_byte_next = {device_address, read_not_write};
                else if (opcode == i2cbm_pkg::CMD_WRITE)
                    shift_byte_next = data_byte;
                else if (opcode == i2cbm_pkg::CMD_READ)
                begin
                    shift_byte_next   = '0;
                    nack_request_next = send_nack;
                end
                act = start_entry.act;
                tick_count_next = TW'(1);
            end
        end
        else if (tick_count_reg < tick_limit)
        begin
            tick_count_next = tick_count_reg + TW'(1);
        end
        else
        begin
            phase_index_next = idx_adv;
            act              = entry.act;
            fin              = entry.fin;
            tick_count_next  = TW'(1);
        end

        case (act)
            i2cbm_pkg::ACT_DRV:
            begin
                drive_next = 1'b1;
                sda_next   = 1'b1;
            end
            i2cbm_pkg::ACT_REL:
            begin
                drive_next = 1'b0;
                sda_next   = 1'b1;
            end
            i2cbm_pkg::ACT_S0: scl_next = 1'b0;
            i2cbm_pkg::ACT_S1: scl_next = 1'b1;
            i2cbm_pkg::ACT_D0: sda_next = 1'b0;
            i2cbm_pkg::ACT_D1: sda_next = 1'b1;
            i2cbm_pkg::ACT_BIT:
            begin
                sda_next        = shift_byte_next[7];
                shift_byte_next = {shift_byte_next[6:0], 1'b0};
                bit_count_next  = bit_count_next + 4'd1;
            end
            i2cbm_pkg::ACT_SACK: ack_next = sda_sample;
            i2cbm_pkg::ACT_SRD:
            begin
                shift_byte_next = {shift_byte_next[6:0], sda_sample};
                bit_count_next  = bit_count_next + 4'd1;
                scl_next        = 1'b0;
            end
            i2cbm_pkg::ACT_SRDDRV:
            begin
                shift_byte_next = {shift_byte_next[6:0], sda_sample};
                bit_count_next  = bit_count_next + 4'd1;
                scl_next        = 1'b0;
                drive_next      = 1'b1;
                sda_next        = 1'b1;
            end
            i2cbm_pkg::ACT_ACKOUT: sda_next = nack_request_next;
            default: ;
        endcase

        if (fin)
        begin
            if (active_command_reg == i2cbm_pkg::CMD_READ)
                read_hold_next = shift_byte_next;
            active_command_next = i2cbm_pkg::CMD_IDLE;
            phase_index_next    = '0;
            tick_count_next     = '0;
            done_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_command_reg <= i2cbm_pkg::CMD_IDLE;
            phase_index_reg    <= '0;
            tick_count_reg     <= '0;
            shift_byte_reg     <= '0;
            bit_count_reg      <= '0;
            nack_request_reg   <= 1'b0;
            scl_reg            <= 1'b1;
            drive_reg          <= 1'b1;
            sda_reg            <= 1'b1;
            ack_reg            <= 1'b1;
            read_hold_reg      <= '0;
        end
        else if (accept)
        begin
            active_command_reg <= active_command_next;
            phase_index_reg    <= phase_index_next;
            tick_count_reg     <= tick_count_next;
            shift_byte_reg     <= shift_byte_next;
            bit_count_reg      <= bit_count_next;
            nack_request_reg   <= nack_request_next;
            scl_reg            <= scl_next;
            drive_reg          <= drive_next;
            sda_reg            <= sda_next;
            ack_reg            <= ack_next;
            read_hold_reg      <= read_hold_next;
        end
    end

    // result register
    logic       out_scl_reg, out_drive_reg, out_sda_reg, out_busy_reg, out_done_reg;
    logic       out_ack_reg;
    logic [7:0] out_read_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_scl_reg   <= scl_next;
            out_drive_reg <= drive_next;
            out_sda_reg   <= sda_next;
            out_busy_reg  <= (active_command_next != i2cbm_pkg::CMD_IDLE);
            out_done_reg  <= done_next;
            out_read_reg  <= read_hold_next;
            out_ack_reg   <= ack_next;
        end
    end

    assign res_valid        = res_valid_reg;
    assign scl_level        = out_scl_reg;
    assign sda_drive_enable = out_drive_reg;
    assign sda_level        = out_sda_reg;
    assign busy_res         = out_busy_reg;
    assign done_res         = out_done_reg;
    assign read_result      = out_read_reg;
    assign ack_seen         = out_ack_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(out_done_reg && out_busy_reg))
        else $error("done and busy reported together");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (active_command_reg == i2cbm_pkg::CMD_IDLE) |->
            (phase_index_reg == '0 && tick_count_reg == '0))
        else $error("idle sequencer holds a phase or tick count");

    a_busy_ticking: assert property (@(posedge clk) disable iff (!rst_n)
        (active_command_reg != i2cbm_pkg::CMD_IDLE) |-> (tick_count_reg != '0))
        else $error("running sequence with zero tick count");

    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit count beyond one byte");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted request produced no result");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C bit-level master. A directed table of
// commands runs first, then random start/address/byte/stop transfers over
// several phase lengths. Every tick's pin and status outputs are checked
// against a tick-accurate model of the phase sequences or a row's pinned snapshot.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT  = 50000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STEADY_TICKS = 100;
    localparam int unsigned MAX_REPORTS  = 20;
    localparam logic [2:0]  OP_SPARE_A   = 3'd5;
    localparam logic [2:0]  OP_SPARE_B   = 3'd6;
    localparam logic [i2cbm_pkg::APB_ADDR_WIDTH-1:0] PHASE_TICKS_ADDR =
        i2cbm_pkg::APB_ADDR_WIDTH'(4 * int'(i2cbm_pkg::REG_PHASE_TICKS));

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] op;
        logic [6:0] addr;
        logic       rnw;
        logic [7:0] data;
        logic       nack;
        logic       sda;
    } tick_t;

    typedef struct packed {
        logic       scl;
        logic       drv;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rd;
        logic       ack;
    } bus_snapshot_t;

    typedef struct packed {
        tick_t         stim;
        logic          noisy;
        logic          has_want;
        bus_snapshot_t want;
    } dir_row_t;

    localparam bus_snapshot_t BUS_AT_RESET = '{scl: 1'b1, drv: 1'b1, sda: 1'b1,
        busy: 1'b0, done: 1'b0, rd: 8'h00, ack: 1'b1};
    localparam bus_snapshot_t BUS_START_TICK = '{scl: 1'b1, drv: 1'b1, sda: 1'b1,
        busy: 1'b1, done: 1'b0, rd: 8'h00, ack: 1'b1};

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [i2cbm_pkg::APB_ADDR_WIDTH-1:0] paddr;
    logic [i2cbm_pkg::APB_DATA_WIDTH-1:0] pwdata;
    logic [i2cbm_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                 pready;
    logic                                 req_valid;
    logic                                 req_stall;
    logic                                 command_valid;
    logic [2:0]                           opcode;
    logic [6:0]                           device_address;
    logic                                 read_not_write;
    logic [7:0]                           data_byte;
    logic                                 send_nack;
    logic                                 sda_sample;
    logic                                 res_valid;
    logic                                 res_stall;
    logic                                 scl_level;
    logic                                 sda_drive_enable;
    logic                                 sda_level;
    logic                                 busy_res;
    logic                                 done_res;
    logic [7:0]                           read_result;
    logic                                 ack_seen;

    // phase lists per command, mirrored from the protocol description
    i2cbm_pkg::action_t phase_plan [5][64];
    int unsigned        plan_len [5];

    // model state
    i2cbm_pkg::cmd_t run_cmd;
    int unsigned     run_phase;
    int unsigned     hold_count;
    logic [7:0]      shreg;
    logic            nack_want;
    logic            scl_q;
    logic            drv_q;
    logic            sda_q;
    logic            ack_q;
    logic [7:0]      rd_byte;
    logic [15:0]     cfg_ticks;

    bus_snapshot_t expected_bus [$];
    dir_row_t      rows [$];
    int unsigned   errors = 0;
    int unsigned   ticks_sent = 0;
    int unsigned   seqs_run = 0;
    int unsigned   cycle_count = 0;
    logic          steady = 1'b0;
    logic          hold_req = 1'b0;

    i2c_bit_level_master_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .command_valid    (command_valid),
        .opcode           (opcode),
        .device_address   (device_address),
        .read_not_write   (read_not_write),
        .data_byte        (data_byte),
        .send_nack        (send_nack),
        .sda_sample       (sda_sample),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .scl_level        (scl_level),
        .sda_drive_enable (sda_drive_enable),
        .sda_level        (sda_level),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_result      (read_result),
        .ack_seen         (ack_seen)
    );

    always #5 clk = ~clk;

    function automatic void add_step(input i2cbm_pkg::cmd_t c, input i2cbm_pkg::action_t a);
        phase_plan[int'(c)][plan_len[int'(c)]] = a;
        plan_len[int'(c)]++;
    endfunction

    function automatic void add_ack_tail(input i2cbm_pkg::cmd_t c);
        add_step(c, i2cbm_pkg::ACT_REL);
        add_step(c, i2cbm_pkg::ACT_S0);
        add_step(c, i2cbm_pkg::ACT_D1);
        add_step(c, i2cbm_pkg::ACT_S1);
        add_step(c, i2cbm_pkg::ACT_SACK);
        add_step(c, i2cbm_pkg::ACT_S0);
    endfunction

    function automatic void build_plan();
        for (int c = 0; c < 5; c++)
            plan_len[c] = 0;
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_DRV);
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_D1);
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_S1);
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_D0);
        add_step(i2cbm_pkg::CMD_START, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_DRV);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_D0);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_S1);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_D1);
        add_step(i2cbm_pkg::CMD_STOP, i2cbm_pkg::ACT_NOP);
        add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_DRV);
        add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_S0);
        for (int b = 0; b < 8; b++)
        begin
            add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_S0);
            add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_BIT);
            add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_S1);
            add_step(i2cbm_pkg::CMD_ADDR, i2cbm_pkg::ACT_S0);
        end
        add_ack_tail(i2cbm_pkg::CMD_ADDR);
        add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_DRV);
        add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_S0);
        for (int b = 0; b < 8; b++)
        begin
            add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_S0);
            add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_BIT);
            add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_S1);
        end
        add_step(i2cbm_pkg::CMD_WRITE, i2cbm_pkg::ACT_S0);
        add_ack_tail(i2cbm_pkg::CMD_WRITE);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_REL);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_D1);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S1);
        for (int b = 0; b < 7; b++)
        begin
            add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_SRD);
            add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S1);
        end
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_SRDDRV);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S0);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_ACKOUT);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S1);
        add_step(i2cbm_pkg::CMD_READ, i2cbm_pkg::ACT_S0);
    endfunction

    function automatic void do_action(input i2cbm_pkg::action_t a, input logic s);
        case (a) inside
            i2cbm_pkg::ACT_DRV:
            begin
                drv_q = 1'b1;
                sda_q = 1'b1;
            end
            i2cbm_pkg::ACT_REL:
            begin
                drv_q = 1'b0;
                sda_q = 1'b1;
            end
            i2cbm_pkg::ACT_S0: scl_q = 1'b0;
            i2cbm_pkg::ACT_S1: scl_q = 1'b1;
            i2cbm_pkg::ACT_D0: sda_q = 1'b0;
            i2cbm_pkg::ACT_D1: sda_q = 1'b1;
            i2cbm_pkg::ACT_BIT:
            begin
                sda_q = shreg[7];
                shreg = {shreg[6:0], 1'b0};
            end
            i2cbm_pkg::ACT_SACK: ack_q = s;
            i2cbm_pkg::ACT_SRD, i2cbm_pkg::ACT_SRDDRV:
            begin
                shreg = {shreg[6:0], s};
                scl_q = 1'b0;
                if (a == i2cbm_pkg::ACT_SRDDRV)
                begin
                    drv_q = 1'b1;
                    sda_q = 1'b1;
                end
            end
            i2cbm_pkg::ACT_ACKOUT: sda_q = nack_want;
            default: ;
        endcase
    endfunction

    // advances the model by one tick and returns the outputs after it
    function automatic bus_snapshot_t i2c_tick(input tick_t t);
        bus_snapshot_t r;
        int unsigned   lim;
        logic          fin;
        fin = 1'b0;
        lim = (cfg_ticks == 16'd0) ? 32'd1 : 32'(cfg_ticks);
        if (run_cmd == i2cbm_pkg::CMD_IDLE)
        begin
            if (t.cmd_valid && t.op <= i2cbm_pkg::CMD_READ)
            begin
                run_cmd = i2cbm_pkg::cmd_t'(t.op);
                run_phase = 0;
                case (run_cmd)
                    i2cbm_pkg::CMD_ADDR: shreg = {t.addr, t.rnw};
                    i2cbm_pkg::CMD_WRITE: shreg = t.data;
                    i2cbm_pkg::CMD_READ:
                    begin
                        shreg = 8'h00;
                        nack_want = t.nack;
                    end
                    default: ;
                endcase
                do_action(phase_plan[int'(run_cmd)][0], t.sda);
                hold_count = 1;
                seqs_run++;
            end
        end
        else if (hold_count < lim)
        begin
            hold_count++;
        end
        else
        begin
            run_phase++;
            do_action(phase_plan[int'(run_cmd)][run_phase], t.sda);
            if (run_phase == plan_len[int'(run_cmd)] - 1)
            begin
                if (run_cmd == i2cbm_pkg::CMD_READ)
                    rd_byte = shreg;
                run_cmd = i2cbm_pkg::CMD_IDLE;
                run_phase = 0;
                hold_count = 0;
                fin = 1'b1;
            end
            else
            begin
                hold_count = 1;
            end
        end
        r.scl = scl_q;
        r.drv = drv_q;
        r.sda = sda_q;
        r.busy = (run_cmd != i2cbm_pkg::CMD_IDLE);
        r.done = fin;
        r.rd = rd_byte;
        r.ack = ack_q;
        return r;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.cmd_valid = 1'($urandom_range(0, 1));
        t.op = 3'($urandom_range(0, 7));
        t.addr = 7'($urandom_range(0, 127));
        t.rnw = 1'($urandom_range(0, 1));
        t.data = 8'($urandom_range(0, 255));
        t.nack = 1'($urandom_range(0, 1));
        t.sda = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic dir_row_t mk_row(input logic v, input logic [2:0] op,
                                        input logic [6:0] a, input logic rnw,
                                        input logic [7:0] d, input logic nack,
                                        input logic sda, input logic noisy,
                                        input logic has_want, input bus_snapshot_t want);
        dir_row_t r;
        r.stim = '{cmd_valid: v, op: op, addr: a, rnw: rnw, data: d, nack: nack, sda: sda};
        r.noisy = noisy;
        r.has_want = has_want;
        r.want = want;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        bus_snapshot_t w;
        if (expected_bus.size() == 0)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: result with no request outstanding", $time);
            errors++;
            return;
        end
        w = expected_bus.pop_front();
        check_field("scl_level", 8'(w.scl), 8'(scl_level));
        check_field("sda_drive_enable", 8'(w.drv), 8'(sda_drive_enable));
        check_field("sda_level", 8'(w.sda), 8'(sda_level));
        check_field("busy_res", 8'(w.busy), 8'(busy_res));
        check_field("done_res", 8'(w.done), 8'(done_res));
        check_field("read_result", w.rd, read_result);
        check_field("ack_seen", 8'(w.ack), 8'(ack_seen));
    endtask

    task automatic put_tick(input tick_t t, input logic has_want,
                            input bus_snapshot_t want);
        int unsigned   gap;
        bus_snapshot_t p;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 34)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command_valid  <= t.cmd_valid;
        opcode         <= t.op;
        device_address <= t.addr;
        read_not_write <= t.rnw;
        data_byte      <= t.data;
        send_nack      <= t.nack;
        sda_sample     <= t.sda;
        req_valid      <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        p = i2c_tick(t);
        expected_bus.push_back(has_want ? want : p);
        ticks_sent++;
    endtask

    // runs ticks until the sequence in flight has finished
    task automatic finish_sequence(input logic pin_sda, input logic use_pin,
                                   input logic noisy);
        tick_t t;
        while (run_cmd != i2cbm_pkg::CMD_IDLE)
        begin
            t = random_tick();
            t.cmd_valid = noisy;
            if (use_pin)
                t.sda = pin_sda;
            put_tick(t, 1'b0, BUS_AT_RESET);
        end
    endtask

    task automatic walk_rows();
        foreach (rows[i])
        begin
            put_tick(rows[i].stim, rows[i].has_want, rows[i].want);
            finish_sequence(rows[i].stim.sda, 1'b1, rows[i].noisy);
        end
        rows.delete();
    endtask

    task automatic issue(input tick_t t);
        tick_t idle_t;
        t.cmd_valid = 1'b1;
        put_tick(t, 1'b0, BUS_AT_RESET);
        finish_sequence(1'b0, 1'b0, $urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 2))
        begin
            idle_t = random_tick();
            idle_t.cmd_valid = 1'b0;
            put_tick(idle_t, 1'b0, BUS_AT_RESET);
        end
    endtask

    task automatic run_transaction();
        tick_t t;
        logic  dir;
        t = random_tick();
        t.op = i2cbm_pkg::CMD_START;
        issue(t);
        t = random_tick();
        t.op = i2cbm_pkg::CMD_ADDR;
        dir = t.rnw;
        issue(t);
        repeat ($urandom_range(0, 3))
        begin
            t = random_tick();
            t.op = dir ? i2cbm_pkg::CMD_READ : i2cbm_pkg::CMD_WRITE;
            issue(t);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            t = random_tick();
            t.op = i2cbm_pkg::CMD_STOP;
            issue(t);
        end
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned goal;
        tick_t       t;
        goal = seqs_run + count;
        while (seqs_run < goal)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                t = random_tick();
                put_tick(t, 1'b0, BUS_AT_RESET);
                finish_sequence(1'b0, 1'b0, 1'b0);
            end
            else
            begin
                run_transaction();
            end
        end
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        req_valid <= 1'b0;
        while (expected_bus.size() != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PHASE_TICKS_ADDR;
        pwdata  <= i2cbm_pkg::APB_DATA_WIDTH'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_ticks = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", v[7:0], prdata[7:0]);
        check_field("prdata", v[15:8], prdata[15:8]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_bus.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                check_result();
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= !steady && ($urandom_range(0, 99) < 34);
            end
        end
    end

    initial
    begin
        tick_t t;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_valid      <= 1'b0;
        command_valid  <= 1'b0;
        opcode         <= i2cbm_pkg::CMD_START;
        device_address <= '0;
        read_not_write <= 1'b0;
        data_byte      <= '0;
        send_nack      <= 1'b0;
        sda_sample     <= 1'b1;

        build_plan();
        run_cmd    = i2cbm_pkg::CMD_IDLE;
        run_phase  = 0;
        hold_count = 0;
        shreg      = 8'h00;
        nack_want  = 1'b0;
        scl_q      = 1'b1;
        drv_q      = 1'b1;
        sda_q      = 1'b1;
        ack_q      = 1'b1;
        rd_byte    = 8'h00;
        cfg_ticks  = i2cbm_pkg::PHASE_TICKS_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands at the reset phase length, bus pinned per row
        rows.push_back(mk_row(1'b0, i2cbm_pkg::CMD_START, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                              1'b0, 1'b1, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, OP_SPARE_A, 7'h7f, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0,
                              1'b1, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, OP_SPARE_B, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0,
                              1'b1, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_IDLE, 7'h2a, 1'b1, 8'h5a, 1'b1, 1'b1,
                              1'b0, 1'b1, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_START, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                              1'b0, 1'b1, BUS_START_TICK));
        walk_rows();

        // zero phase length behaves as one
        set_phase_ticks(16'd0);
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_ADDR, 7'h7f, 1'b0, 8'h00, 1'b0, 1'b0,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'hff, 1'b0, 1'b0,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_WRITE, 7'h7f, 1'b1, 8'h00, 1'b1, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_START, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_ADDR, 7'h00, 1'b1, 8'hff, 1'b1, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_READ, 7'h7f, 1'b1, 8'hff, 1'b1, 1'b0,
                              1'b1, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_WRITE, 7'h55, 1'b0, 8'ha5, 1'b0, 1'b0,
                              1'b1, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_STOP, 7'h7f, 1'b1, 8'hff, 1'b1, 1'b0,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_READ, 7'h2a, 1'b0, 8'h3c, 1'b1, 1'b1,
                              1'b0, 1'b0, BUS_AT_RESET));
        rows.push_back(mk_row(1'b1, i2cbm_pkg::CMD_ADDR, 7'h55, 1'b1, 8'hc3, 1'b0, 1'b0,
                              1'b0, 1'b0, BUS_AT_RESET));
        walk_rows();

        set_phase_ticks(16'd1);
        hold_req = 1'b1;
        random_traffic(5);
        set_phase_ticks(16'd2);
        random_traffic(2);

        // full-range phase length held with no idling, then cut short
        steady = 1'b1;
        set_phase_ticks(16'hffff);
        t = random_tick();
        t.cmd_valid = 1'b1;
        t.op = i2cbm_pkg::CMD_START;
        put_tick(t, 1'b0, BUS_AT_RESET);
        repeat (STEADY_TICKS)
        begin
            t = random_tick();
            put_tick(t, 1'b0, BUS_AT_RESET);
        end
        set_phase_ticks(16'd3);
        finish_sequence(1'b0, 1'b0, 1'b1);
        steady = 1'b0;

        req_valid <= 1'b0;
        while (expected_bus.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Checked %0d ticks, %0d command sequences, %0d cycles.",
                 ticks_sent, seqs_run, cycle_count);
        $display("Phase lengths 10, 0, 1, 2, 65535 cut to 3; spare and busy commands.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
